// ===== rtl/cht_pkg.sv =====
// Package with the types, constants and codes of the chained hash table.
`default_nettype none
package cht_pkg;
  localparam int BUCKETS = 64;
  localparam int NODES = 256;
  localparam int BW = $clog2(BUCKETS);
  localparam int NW = $clog2(NODES);
  localparam int KEY_W = 31;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_FOUND = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [0:0] REG_BUCKET_COUNT = 1'd0;
  localparam logic [0:0] REG_MAX_ENTRIES = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_DECIDE, S_READ, S_CHECK, S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/cht_if.sv =====
// Valid/ready channel interfaces for input and result beats.
`default_nettype none
interface cht_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic [30:0] key;
  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface cht_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [8:0] position;
  modport source (output valid, output status, output position, input ready);
  modport sink (input valid, input status, input position, output ready);
endinterface
`default_nettype wire

// ===== rtl/chained_hash_table.sv =====
// Top level of the chained hash table with an APB register port.
// Usage: each input beat on in_ch carries a mode (insert or lookup) and a key.
// The bucket is the key modulo bucket_count (0 acts as 1, above 64 as 64).
// An insert takes the next free node and links it at the tail of its
// bucket's chain unless max_entries nodes are in use, then it is dropped.
// A lookup walks the chain and reports the 1-based position of the first
// matching node, or not found. One result beat leaves on out_ch per input.
// Steps: the bit-serial remainder unit reduces the key, then the bucket is
// decided; a lookup of a used bucket then reads and checks one node at a
// time through the one-read node memory until a match or the chain's tail,
// and the result is presented in S_DONE. One item is in work at a time;
// in_ch.ready is low meanwhile.
// A result waits in its output register while out_ch.ready is low, and the
// next item is taken once it has gone. Reset is synchronous: all buckets
// empty, count zero, registers at 64 and 256. No clearing pass is needed.
// Registers: bucket_count at 0x0, max_entries at 0x4.
`default_nettype none
module chained_hash_table (
  input  wire logic       clk,
  input  wire logic       rst,
  cht_in_if.sink          in_ch,
  cht_out_if.source       out_ch,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  localparam int PW = cht_pkg::NW + 1;

  logic [6:0] bucket_count;
  logic [8:0] max_entries;
  cht_pkg::state_t state, state_next;

  logic [cht_pkg::BUCKETS-1:0] bucket_used;
  logic [cht_pkg::NW-1:0] bucket_head [cht_pkg::BUCKETS];
  logic [cht_pkg::NW-1:0] bucket_tail [cht_pkg::BUCKETS];
  logic [cht_pkg::KEY_W-1:0] node_key [cht_pkg::NODES];
  logic [cht_pkg::NW-1:0] node_link [cht_pkg::NODES];
  logic [PW-1:0] stored_count;

  logic mode;
  logic [30:0] key;
  logic [cht_pkg::BW-1:0] bkt;
  logic [cht_pkg::NW-1:0] ptr;
  logic [cht_pkg::NW-1:0] tail;
  logic [8:0] pos;
  logic [30:0] rd_key;
  logic [cht_pkg::NW-1:0] rd_link;
  logic [1:0] status;
  logic [8:0] position;
  logic [6:0] divisor;
  logic [8:0] limit;
  logic div_start, div_done;
  logic [6:0] remainder;
  logic in_fire;

  // APB registers.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= 7'd64;
      max_entries <= 9'd256;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        cht_pkg::REG_BUCKET_COUNT: bucket_count <= pwdata[6:0];
        cht_pkg::REG_MAX_ENTRIES: max_entries <= pwdata[8:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == cht_pkg::REG_MAX_ENTRIES) prdata = {23'd0, max_entries};
    else prdata = {25'd0, bucket_count};
  end

  // Effective modulus and entry limit.
  always_comb begin
    if (bucket_count == 7'd0) divisor = 7'd1;
    else if (bucket_count > 7'(cht_pkg::BUCKETS)) divisor = 7'(cht_pkg::BUCKETS);
    else divisor = bucket_count;
    if (max_entries > 9'(cht_pkg::NODES)) limit = 9'(cht_pkg::NODES);
    else limit = max_entries;
  end

  assign in_fire = in_ch.valid && in_ch.ready;
  assign div_start = in_fire;

  cht_mod u_mod (
    .clk(clk), .rst(rst), .start(div_start), .dividend(in_ch.key),
    .divisor(divisor), .done(div_done), .remainder(remainder)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      cht_pkg::S_IDLE: if (in_fire) state_next = cht_pkg::S_DIV;
      cht_pkg::S_DIV: if (div_done) state_next = cht_pkg::S_DECIDE;
      cht_pkg::S_DECIDE: begin
        if (mode == cht_pkg::MODE_INSERT || !bucket_used[bkt]) state_next = cht_pkg::S_DONE;
        else state_next = cht_pkg::S_READ;
      end
      cht_pkg::S_READ: state_next = cht_pkg::S_CHECK;
      cht_pkg::S_CHECK: begin
        if (rd_key == key || ptr == tail) state_next = cht_pkg::S_DONE;
        else state_next = cht_pkg::S_READ;
      end
      cht_pkg::S_DONE: if (out_ch.ready) state_next = cht_pkg::S_IDLE;
      default: state_next = cht_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ch.ready = (state == cht_pkg::S_IDLE);
    out_ch.valid = (state == cht_pkg::S_DONE);
    out_ch.status = status;
    out_ch.position = position;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cht_pkg::S_IDLE;
    else state <= state_next;
  end

  // Control state: bucket valid bits and node count.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_used <= '0;
      stored_count <= '0;
    end else if (state == cht_pkg::S_DECIDE && mode == cht_pkg::MODE_INSERT &&
                 9'(stored_count) < limit) begin
      bucket_used[bkt] <= 1'b1;
      stored_count <= stored_count + PW'(1);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode <= in_ch.mode;
      key <= in_ch.key;
    end
    if (div_done) bkt <= cht_pkg::BW'(remainder);
    if (state == cht_pkg::S_DECIDE) begin
      ptr <= bucket_head[bkt];
      tail <= bucket_tail[bkt];
      pos <= 9'd1;
      position <= 9'd0;
      if (mode == cht_pkg::MODE_INSERT) begin
        if (9'(stored_count) < limit) status <= cht_pkg::ST_INSERTED;
        else status <= cht_pkg::ST_DROPPED;
      end else begin
        status <= cht_pkg::ST_MISSING;
      end
    end
    if (state == cht_pkg::S_CHECK) begin
      if (rd_key == key) begin
        status <= cht_pkg::ST_FOUND;
        position <= pos;
      end
      ptr <= rd_link;
      pos <= pos + 9'd1;
    end
  end

  // Bucket tables and node memory.
  always_ff @(posedge clk) begin
    if (state == cht_pkg::S_DECIDE && mode == cht_pkg::MODE_INSERT &&
        9'(stored_count) < limit) begin
      if (!bucket_used[bkt]) bucket_head[bkt] <= stored_count[cht_pkg::NW-1:0];
      bucket_tail[bkt] <= stored_count[cht_pkg::NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == cht_pkg::S_DECIDE && mode == cht_pkg::MODE_INSERT &&
        9'(stored_count) < limit) begin
      node_key[stored_count[cht_pkg::NW-1:0]] <= key;
    end
    if (state == cht_pkg::S_READ) rd_key <= node_key[ptr];
  end

  // Link memory: the link write of an insert into a used bucket is registered from S_DECIDE.
  logic link_we;
  logic [cht_pkg::NW-1:0] link_addr, link_data;
  always_ff @(posedge clk) begin
    if (rst) link_we <= 1'b0;
    else link_we <= (state == cht_pkg::S_DECIDE && mode == cht_pkg::MODE_INSERT &&
                     9'(stored_count) < limit && bucket_used[bkt]);
    link_addr <= bucket_tail[bkt];
    link_data <= stored_count[cht_pkg::NW-1:0];
  end
  always_ff @(posedge clk) begin
    if (link_we) node_link[link_addr] <= link_data;
    if (state == cht_pkg::S_READ) rd_link <= node_link[ptr];
  end

  // Assertions.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_count_lim: assert property (@(posedge clk) disable iff (rst)
    stored_count <= PW'(cht_pkg::NODES)) else $error("node count beyond pool");
  a_found_pos: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == cht_pkg::ST_FOUND) |-> out_ch.position != 9'd0)
    else $error("found with zero position");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.status))
    else $error("result dropped while stalled");
endmodule
`default_nettype wire

// ===== rtl/cht_mod.sv =====
// Restoring remainder unit: key modulo a divisor, one bit a cycle.
`default_nettype none
module cht_mod (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [30:0] dividend,
  input  wire logic [6:0]  divisor,
  output logic             done,
  output logic [6:0]       remainder
);
  logic [30:0] shreg;
  logic [6:0]  rem;
  logic [6:0]  dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [7:0]  trial;

  // Shift in the next dividend bit and subtract where it fits.
  assign trial = {rem, shreg[30]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd30) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem <= 7'd0;
      dvs <= divisor;
    end else if (busy) begin
      shreg <= {shreg[29:0], 1'b0};
      if (trial >= {1'b0, dvs}) rem <= 7'(trial - {1'b0, dvs});
      else rem <= trial[6:0];
    end
  end

  assign remainder = rem;
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the chained hash table: random and directed beats checked against a predictor.
`timescale 1ns / 1ps
module tb;
  localparam int CYCLE_LIMIT = 5000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cht_in_if in_ch ();
  cht_out_if out_ch ();

  chained_hash_table u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  typedef struct packed {
    logic mode;
    logic [30:0] key;
  } op_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] position;
  } answer_t;

  // Predictor state.
  logic [6:0] cfg_buckets;
  logic [8:0] cfg_limit;
  logic used_q [cht_pkg::BUCKETS];
  logic [cht_pkg::NW-1:0] head_q [cht_pkg::BUCKETS];
  logic [cht_pkg::NW-1:0] tail_q [cht_pkg::BUCKETS];
  logic [30:0] nkey_q [cht_pkg::NODES];
  logic [cht_pkg::NW-1:0] nlink_q [cht_pkg::NODES];
  int count_q;

  op_t pending_ops [$];
  answer_t expected_answers [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_send = 1'b0;
  int cycles = 0;
  logic [30:0] used_keys [$];

  function automatic answer_t table_step(op_t op);
    answer_t a;
    int nb, lim, b, p, t, pos;
    if (cfg_buckets == 7'd0) nb = 1;
    else if (int'(cfg_buckets) > cht_pkg::BUCKETS) nb = cht_pkg::BUCKETS;
    else nb = int'(cfg_buckets);
    lim = (int'(cfg_limit) > cht_pkg::NODES) ? cht_pkg::NODES : int'(cfg_limit);
    b = int'(op.key) % nb;
    a.position = '0;
    if (op.mode == cht_pkg::MODE_INSERT) begin
      if (count_q < lim) begin
        nkey_q[count_q] = op.key;
        nlink_q[count_q] = '0;
        if (used_q[b]) begin
          nlink_q[tail_q[b]] = count_q[cht_pkg::NW-1:0];
        end else begin
          used_q[b] = 1'b1;
          head_q[b] = count_q[cht_pkg::NW-1:0];
        end
        tail_q[b] = count_q[cht_pkg::NW-1:0];
        count_q++;
        a.status = cht_pkg::ST_INSERTED;
      end else begin
        a.status = cht_pkg::ST_DROPPED;
      end
    end else begin
      a.status = cht_pkg::ST_MISSING;
      if (used_q[b]) begin
        p = int'(head_q[b]);
        t = int'(tail_q[b]);
        pos = 1;
        for (int s = 0; s < cht_pkg::NODES; s++) begin
          if (nkey_q[p] == op.key) begin
            a.status = cht_pkg::ST_FOUND;
            a.position = pos[8:0];
            break;
          end
          if (p == t) break;
          p = int'(nlink_q[p]);
          pos++;
        end
      end
    end
    return a;
  endfunction

  // Driver: presents pending beats with random idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the beat
    end else begin
      if (pending_ops.size() > 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        op_t op;
        op = pending_ops.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.mode <= op.mode;
        in_ch.key <= op.key;
        expected_answers.push_back(table_step(op));
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: random stalls and a field-by-field comparison.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_answers.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (out_ch.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_ch.status);
            errors++;
          end
          if (out_ch.position !== e.position) begin
            $error("position expected %0d actual %0d", e.position, out_ch.position);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic reg_write(input logic [0:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == cht_pkg::REG_BUCKET_COUNT) cfg_buckets = value[6:0];
    else cfg_limit = value[8:0];
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || expected_answers.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic op_t pick_op(logic [6:0] nb);
    op_t op;
    op.mode = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: op.key = 31'($urandom());
      1: op.key = 31'($urandom_range(200));
      default: begin
        if (used_keys.size() > 0 && op.mode == cht_pkg::MODE_LOOKUP) begin
          op.key = used_keys[$urandom_range(used_keys.size() - 1)];
        end else begin
          op.key = 31'(($urandom_range(16) * (nb == 7'd0 ? 32'd1 : 32'(nb))) +
                       $urandom_range(3) + ($urandom_range(1) << 30));
        end
      end
    endcase
    if (op.mode == cht_pkg::MODE_INSERT) used_keys.push_back(op.key);
    return op;
  endfunction

  // Stimulus phases with varied settings and idling.
  initial begin
    op_t op;
    logic [6:0] nb_set [6];
    logic [8:0] lim_set [6];
    nb_set = '{7'd1, 7'd0, 7'd127, 7'd7, 7'd64, 7'd3};
    lim_set = '{9'd256, 9'd0, 9'd511, 9'd40, 9'd300, 9'd255};
    cfg_buckets = 7'd64;
    cfg_limit = 9'd256;
    count_q = 0;
    for (int i = 0; i < cht_pkg::BUCKETS; i++) used_q[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at reset settings: extremes, chains, misses.
    op = '{cht_pkg::MODE_INSERT, 31'h7fffffff}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_INSERT, 31'd0}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_INSERT, 31'd64}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_INSERT, 31'd128}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_INSERT, 31'd64}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_LOOKUP, 31'd128}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_LOOKUP, 31'd64}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_LOOKUP, 31'd0}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_LOOKUP, 31'h7fffffff}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_LOOKUP, 31'd192}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_LOOKUP, 31'd5}; pending_ops.push_back(op);
    drain();

    // Entry limit and bucket-count changes after inserts.
    reg_write(cht_pkg::REG_MAX_ENTRIES, 32'd6);
    reg_write(cht_pkg::REG_BUCKET_COUNT, 32'd0);
    op = '{cht_pkg::MODE_INSERT, 31'd9}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_INSERT, 31'd10}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_LOOKUP, 31'd9}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_LOOKUP, 31'd0}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_LOOKUP, 31'd64}; pending_ops.push_back(op);
    drain();
    reg_write(cht_pkg::REG_BUCKET_COUNT, 32'd100);
    reg_write(cht_pkg::REG_MAX_ENTRIES, 32'd511);
    op = '{cht_pkg::MODE_LOOKUP, 31'd64}; pending_ops.push_back(op);
    op = '{cht_pkg::MODE_LOOKUP, 31'd10}; pending_ops.push_back(op);
    drain();

    // Random phases; the table fills to 256 and then keeps dropping.
    for (int ph = 0; ph < 24; ph++) begin
      reg_write(cht_pkg::REG_BUCKET_COUNT, {25'd0, nb_set[ph % 6]});
      reg_write(cht_pkg::REG_MAX_ENTRIES, {23'd0, lim_set[(ph / 2) % 6]});
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 61; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 61; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int i = 0; i < 68; i++) begin
        pending_ops.push_back(pick_op(cfg_buckets));
        if (ph == 5 && i == 30) begin
          // Hold the sender until every expected result is back.
          while (pending_ops.size() > 1 || in_ch.valid) @(posedge clk);
          hold_send = 1'b1;
          while (expected_answers.size() > 0) @(posedge clk);
          hold_send = 1'b0;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
